[rtl/core/psle_pkg.sv]
// ----------------------------------------------------------------------------
// psle_pkg
// Shared widths, register indexes and table builders for the Phong lobe block.
// ----------------------------------------------------------------------------
package psle_pkg;

  localparam int CoordW = 16;
  localparam int DotW   = 41;   // r.wo, exact
  localparam int LobeW  = 15;   // lobe, Q.14, at most 1.0
  localparam int LogW   = 17;   // log table entry, Q.16
  localparam int ExpW   = 31;   // exp table entry, Q.30
  localparam int CfgAddrW = 3;

  localparam logic [CfgAddrW-1:0] RegSpecGain  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegColorRed  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegColorGrn  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegColorBlu  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegShininess = 3'd4;

  localparam longint unsigned One30 = 64'd1073741824;

  // 2^30 * 2^(-2^-(k+1)) rounded, k = 0 is the square root of one half
  localparam logic [31:0] ExpStep [12] = '{
    32'd759250125,  32'd902905651,  32'd984625594,  32'd1028218693,
    32'd1050733751, 32'd1062175491, 32'd1067942999, 32'd1070838486,
    32'd1072289173, 32'd1073015252, 32'd1073378477, 32'd1073560135
  };

  typedef logic [CoordW-1:0] word_t;

  // log2(1 + idx/2^bits) in Q.16 by repeated squaring
  function automatic logic [LogW-1:0] log_entry(input int unsigned idx,
                                                input int unsigned bits);
    longint unsigned x;
    logic [LogW:0] acc;
    x = One30 + (longint'(idx) << (30 - bits));
    acc = '0;
    for (int n = 0; n < 17; n++) begin
      x = (x * x) >> 30;
      acc = {acc[LogW-1:0], 1'b0};
      if (x >= 2 * One30) begin
        acc[0] = 1'b1;
        x = x >> 1;
      end
    end
    acc = (acc + 18'd1) >> 1;
    return acc[LogW-1:0];
  endfunction

  // 2^30 * 2^(-idx/2^bits)
  function automatic logic [ExpW-1:0] exp_entry(input int unsigned idx,
                                                input int unsigned bits);
    longint unsigned acc;
    acc = One30;
    for (int b = 0; b < 12; b++) begin
      if (b < bits && ((idx >> b) & 1) == 1)
        acc = (acc * longint'(ExpStep[bits-1-b]) + (One30 >> 1)) >> 30;
    end
    return acc[ExpW-1:0];
  endfunction

endpackage

[rtl/core/psle_reflect.sv]
// ----------------------------------------------------------------------------
// psle_reflect
// Reflects wi about n and forms d = r.wo exactly, over five stages.
// ----------------------------------------------------------------------------
module psle_reflect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [psle_pkg::CoordW-1:0] nx, ny, nz,
  input  logic signed [psle_pkg::CoordW-1:0] ix, iy, iz,
  input  logic signed [psle_pkg::CoordW-1:0] ox, oy, oz,
  output logic                             d_valid,
  output logic signed [psle_pkg::DotW-1:0]   d
);

  logic [3:0] vld;

  logic signed [15:0] n1 [3], w1 [3], o1 [3];
  logic signed [31:0] pk [3];
  logic signed [15:0] n2 [3], w2 [3], o2 [3];
  logic signed [32:0] k;
  logic signed [15:0] w3 [3], o3 [3];
  logic signed [48:0] nk [3];
  logic signed [38:0] m [3];
  logic signed [22:0] r [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      r[i] = 23'(nk[i] >>> 27) - 23'(w3[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      d_valid <= 1'b0;
    end else begin
      vld <= {vld[2:0], in_valid};
      d_valid <= vld[3];
    end
    // products of n and wi
    n1[0] <= nx; n1[1] <= ny; n1[2] <= nz;
    w1[0] <= ix; w1[1] <= iy; w1[2] <= iz;
    o1[0] <= ox; o1[1] <= oy; o1[2] <= oz;
    pk[0] <= nx * ix;
    pk[1] <= ny * iy;
    pk[2] <= nz * iz;
    // k = n.wi
    n2 <= n1; w2 <= w1; o2 <= o1;
    k <= 33'(pk[0]) + 33'(pk[1]) + 33'(pk[2]);
    // n k
    w3 <= w2; o3 <= o2;
    for (int i = 0; i < 3; i++)
      nk[i] <= 49'(n2[i]) * 49'(k);
    // r.wo terms
    for (int i = 0; i < 3; i++)
      m[i] <= 39'(r[i]) * 39'(o3[i]);
    d <= 41'(m[0]) + 41'(m[1]) + 41'(m[2]);
  end

endmodule

[rtl/core/psle_lobe.sv]
// ----------------------------------------------------------------------------
// psle_lobe
// lobe = d^shininess via log2 and exp2 tables, over four stages.
// ----------------------------------------------------------------------------
module psle_lobe #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               d_valid,
  input  logic signed [psle_pkg::DotW-1:0]   d,
  input  logic [15:0]                        shininess,
  output logic                               lobe_valid,
  output logic                               hit,
  output logic [psle_pkg::LobeW-1:0]         lobe
);

  localparam int TabN = 1 << LOG_TABLE_BITS;

  logic [psle_pkg::LogW-1:0] log_tab [TabN];
  logic [psle_pkg::ExpW-1:0] exp_tab [TabN];

  for (genvar gi = 0; gi < TabN; gi++) begin : g_tab
    assign log_tab[gi] = psle_pkg::log_entry(gi, LOG_TABLE_BITS);
    assign exp_tab[gi] = psle_pkg::exp_entry(gi, LOG_TABLE_BITS);
  end

  logic [2:0] vld;
  logic [2:0] hit_p;
  logic [2:0] clamp_p;

  // stage 1: leading one and table index
  logic        pos, big;
  logic [27:0] ud, n28;
  logic [4:0]  msb;
  logic [4:0]  p1;
  logic [LOG_TABLE_BITS-1:0] idx1;

  always_comb begin
    pos = (d > 0);
    big = (d[psle_pkg::DotW-2:28] != '0);
    ud  = d[27:0];
    msb = '0;
    for (int i = 0; i < 28; i++)
      if (ud[i]) msb = 5'(i);
    n28 = ud << (5'd27 - msb);
  end

  // stage 2: -log2 d
  logic [20:0] lg;
  // stage 3: scaled by exponent
  logic [28:0] t;
  logic [36:0] tprod;
  // stage 4: exp2
  logic [12:0] q;
  logic [LOG_TABLE_BITS-1:0] j;
  logic [30:0] l30;
  logic [31:0] rnd;

  always_comb begin
    tprod = 37'(lg) * 37'(shininess);
    q = t[28:16];
    j = t[15 -: LOG_TABLE_BITS];
    l30 = (q > 13'd30) ? '0 : (exp_tab[j] >> q[4:0]);
    rnd = 32'(l30) + 32'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lobe_valid <= 1'b0;
    end else begin
      vld <= {vld[1:0], d_valid};
      lobe_valid <= vld[2];
    end
    hit_p   <= {hit_p[1:0], pos};
    clamp_p <= {clamp_p[1:0], big};
    p1   <= msb;
    idx1 <= n28[26 -: LOG_TABLE_BITS];
    lg   <= {5'd27 - p1 + 5'd1, 16'd0} - 21'(log_tab[idx1]);
    t    <= tprod[36:8];
    hit  <= hit_p[2];
    if (!hit_p[2])
      lobe <= '0;
    else if (clamp_p[2])
      lobe <= 15'd16384;
    else
      lobe <= rnd[30:16];
  end

endmodule

[rtl/core/psle_shade.sv]
// ----------------------------------------------------------------------------
// psle_shade
// Channel = gain * colour * lobe >> 28, saturated, over three stages.
// ----------------------------------------------------------------------------
module psle_shade (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        lobe_valid,
  input  logic                        hit,
  input  logic [psle_pkg::LobeW-1:0]  lobe,
  input  logic [15:0]                 spec_gain,
  input  logic [15:0]                 color_red,
  input  logic [15:0]                 color_green,
  input  logic [15:0]                 color_blue,
  output logic                        done,
  output logic [15:0]                 refl_red,
  output logic [15:0]                 refl_green,
  output logic [15:0]                 refl_blue,
  output logic                        lobe_hit
);

  logic [1:0]  vld;
  logic [1:0]  hit_p;
  logic [30:0] g;
  logic [46:0] pr, pg, pb;

  function automatic logic [15:0] sat(input logic [46:0] v);
    return (v[46:44] != '0) ? 16'hFFFF : v[43:28];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[0], lobe_valid};
      done <= vld[1];
    end
    hit_p <= {hit_p[0], hit};
    g  <= 31'(spec_gain) * 31'(lobe);
    pr <= 47'(g) * 47'(color_red);
    pg <= 47'(g) * 47'(color_green);
    pb <= 47'(g) * 47'(color_blue);
    refl_red   <= sat(pr);
    refl_green <= sat(pg);
    refl_blue  <= sat(pb);
    lobe_hit   <= hit_p[1];
  end

endmodule

[rtl/core/phong_specular_lobe_eval.sv]
// Throughput: one transaction per cycle; busy stays low, start may be held.
// Depth is set by the reflect (5), lobe (4) and shading (3) stages.
// Reset: synchronous; clears the valid pipeline and restores register defaults.
// Results are shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// phong_specular_lobe_eval
// Phong glossy specular lobe evaluator, fully pipelined.
// ----------------------------------------------------------------------------
module phong_specular_lobe_eval #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [psle_pkg::CoordW-1:0]  norm_x,
  input  logic signed [psle_pkg::CoordW-1:0]  norm_y,
  input  logic signed [psle_pkg::CoordW-1:0]  norm_z,
  input  logic signed [psle_pkg::CoordW-1:0]  in_x,
  input  logic signed [psle_pkg::CoordW-1:0]  in_y,
  input  logic signed [psle_pkg::CoordW-1:0]  in_z,
  input  logic signed [psle_pkg::CoordW-1:0]  out_x,
  input  logic signed [psle_pkg::CoordW-1:0]  out_y,
  input  logic signed [psle_pkg::CoordW-1:0]  out_z,
  input  logic                                cfg_we,
  input  logic [psle_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [15:0]                         cfg_wdata,
  output logic                                done,
  output logic [15:0]                         refl_red,
  output logic [15:0]                         refl_green,
  output logic [15:0]                         refl_blue,
  output logic                                lobe_hit
);

  logic [15:0] spec_gain, color_red, color_green, color_blue, shininess;

  always_ff @(posedge clk) begin
    if (rst) begin
      spec_gain   <= 16'd16384;
      color_red   <= 16'd16384;
      color_green <= 16'd16384;
      color_blue  <= 16'd16384;
      shininess   <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_addr)
        psle_pkg::RegSpecGain:  spec_gain   <= cfg_wdata;
        psle_pkg::RegColorRed:  color_red   <= cfg_wdata;
        psle_pkg::RegColorGrn:  color_green <= cfg_wdata;
        psle_pkg::RegColorBlu:  color_blue  <= cfg_wdata;
        psle_pkg::RegShininess: shininess   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  logic                                d_valid;
  logic signed [psle_pkg::DotW-1:0]    d;
  logic                                lobe_valid, hit;
  logic [psle_pkg::LobeW-1:0]          lobe;

  psle_reflect u_reflect (
    .clk(clk), .rst(rst), .in_valid(accept),
    .nx(norm_x), .ny(norm_y), .nz(norm_z),
    .ix(in_x), .iy(in_y), .iz(in_z),
    .ox(out_x), .oy(out_y), .oz(out_z),
    .d_valid(d_valid), .d(d)
  );

  psle_lobe #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lobe (
    .clk(clk), .rst(rst), .d_valid(d_valid), .d(d), .shininess(shininess),
    .lobe_valid(lobe_valid), .hit(hit), .lobe(lobe)
  );

  psle_shade u_shade (
    .clk(clk), .rst(rst), .lobe_valid(lobe_valid), .hit(hit), .lobe(lobe),
    .spec_gain(spec_gain), .color_red(color_red), .color_green(color_green),
    .color_blue(color_blue), .done(done), .refl_red(refl_red),
    .refl_green(refl_green), .refl_blue(refl_blue), .lobe_hit(lobe_hit)
  );

endmodule
